// ----- src/urlpd_pkg.sv -----
// Shared types and constants for the URL percent decoder.
`default_nettype none

package urlpd_pkg;

    // Byte codes that the decoder recognizes or produces.
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    // Most decoded bytes that one input item can cause.
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic
    {
        REG_PLUS_AS_SPACE  = 1'b0,
        REG_KEEP_SLASH     = 1'b1
    } reg_index_t;

    // Escape tracking state.
    typedef enum logic [1:0]
    {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX1 = 2'd2
    } phase_t;

    // Decoded bytes produced by one input item.
    typedef struct packed
    {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } bundle_t;

endpackage

`default_nettype wire

// ----- src/urlpd_front.sv -----
// Front part: accepts input items, tracks escapes and builds result bundles.
`default_nettype none

module urlpd_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic              cfg_data,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic              queue_full,
    output logic                   in_ready,
    output logic                   push,
    output urlpd_pkg::bundle_t     push_data
);
    import urlpd_pkg::*;

    typedef struct packed
    {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    logic    plus_as_space_reg;
    logic    keep_slash_reg;
    phase_t  phase_reg;
    phase_t  phase_next;
    phase_t  phase_mid;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [7:0] held_mid;
    logic    accept;
    hex_t    cur_hex;
    hex_t    held_hex;
    logic [7:0] decoded;
    logic    is_pct;
    bundle_t bundle;

    // Classify a byte as a hex digit of either case.
    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.valid = 1'b1;
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.valid = 1'b1;
            h.value = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.valid = 1'b1;
            h.value = 4'(b - 8'h57);
        end
        return h;
    endfunction

    // Append one byte to a bundle.
    function automatic bundle_t add_byte(input bundle_t bd, input logic [7:0] v);
        bundle_t r;
        r = bd;
        r.bytes[r.count] = v;
        r.count = r.count + CNT_W'(1);
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign cur_hex  = hex_value(in_byte);
    assign held_hex = hex_value(held_reg);
    assign decoded  = {held_hex.value, cur_hex.value};
    assign is_pct   = (in_byte == CHAR_PCT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_as_space_reg <= 1'b0;
            keep_slash_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_PLUS_AS_SPACE: plus_as_space_reg <= cfg_data;
                REG_KEEP_SLASH:    keep_slash_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Escape state after the current byte, before any end-of-string flush.
    always_comb
    begin
        phase_mid = PH_IDLE;
        held_mid  = held_reg;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (cur_hex.valid)
                begin
                    phase_mid = PH_HEX1;
                    held_mid  = in_byte;
                end
                else
                begin
                    phase_mid = is_pct ? PH_PCT : PH_IDLE;
                end
            end
            PH_HEX1:
            begin
                held_mid  = 8'h00;
                phase_mid = (!cur_hex.valid && is_pct) ? PH_PCT : PH_IDLE;
            end
            default:
            begin
                phase_mid = is_pct ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    // Next state: the end of a string returns to idle.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            phase_next = in_last ? PH_IDLE : phase_mid;
            held_next  = in_last ? 8'h00 : held_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Result bytes of the current item.
    always_comb
    begin
        bundle = '0;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (!cur_hex.valid)
                begin
                    bundle = add_byte(bundle, CHAR_PCT);
                end
            end
            PH_HEX1:
            begin
                if (cur_hex.valid)
                begin
                    if (keep_slash_reg && decoded == CHAR_SLASH)
                    begin
                        bundle = add_byte(bundle, CHAR_PCT);
                        bundle = add_byte(bundle, CHAR_TWO);
                        bundle = add_byte(bundle, CHAR_UPPER_F);
                    end
                    else
                    begin
                        bundle = add_byte(bundle, decoded);
                    end
                end
                else
                begin
                    bundle = add_byte(bundle, CHAR_PCT);
                    bundle = add_byte(bundle, held_reg);
                end
            end
            default:
            begin
            end
        endcase

        // The current byte as plain input, when no escape consumed it.
        if ((phase_reg != PH_PCT && phase_reg != PH_HEX1) || !cur_hex.valid)
        begin
            if (plus_as_space_reg && in_byte == CHAR_PLUS)
            begin
                bundle = add_byte(bundle, CHAR_SPACE);
            end
            else if (!is_pct)
            begin
                bundle = add_byte(bundle, in_byte);
            end
        end

        // Flush a pending escape at the end of a string.
        if (in_last)
        begin
            if (phase_mid == PH_PCT)
            begin
                bundle = add_byte(bundle, CHAR_PCT);
            end
            else if (phase_mid == PH_HEX1)
            begin
                bundle = add_byte(bundle, CHAR_PCT);
                bundle = add_byte(bundle, held_mid);
            end
        end
        bundle.last = in_last;
    end

    assign push      = accept && (bundle.count != '0);
    assign push_data = bundle;

endmodule

`default_nettype wire

// ----- src/urlpd_queue.sv -----
// Short queue of result bundles between the front and back parts.
`default_nettype none

module urlpd_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire urlpd_pkg::bundle_t push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output urlpd_pkg::bundle_t      head
);
    import urlpd_pkg::*;

    bundle_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/urlpd_back.sv -----
// Back part: sends bundle bytes one per cycle, unless stalled, via an output register.
`default_nettype none

module urlpd_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    input  wire urlpd_pkg::bundle_t head,
    output logic                    pop,
    output logic                    out_valid,
    output logic [7:0]              out_byte,
    output logic                    out_last,
    input  wire logic               out_ready
);
    import urlpd_pkg::*;

    logic [CNT_W-1:0] sel_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             load;
    logic             final_byte;

    assign load       = !empty && (!valid_reg || out_ready);
    assign final_byte = (sel_reg == head.count - CNT_W'(1));
    assign pop        = load && final_byte;

    // Byte selection within the head bundle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sel_reg   <= final_byte ? '0 : sel_reg + CNT_W'(1);
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[sel_reg];
            last_reg <= head.last && final_byte;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ----- src/url_percent_decoder.sv -----
// Top level of the streaming URL percent decoder.
//
// Input items arrive on the s_axis group, one encoded byte each, with tlast
// marking the final byte of a string. Decoded bytes leave on the m_axis group,
// one per item, with tlast on the final decoded byte of a string.
// Two registers are written through cfg_we/cfg_index/cfg_data; the user is
// to write them only while idle, which the block does not enforce: index 0
// plus_as_space (reset 0), index 1 keep_encoded_slash (reset 1). The front
// part takes one input item per cycle while the queue is not full and builds
// zero to three result bytes for it; a four-entry queue holds those bundles
// and the back part sends one byte per cycle from its output register while
// the receiver is ready. A byte accepted at the input is written into the
// queue, then loaded into the output register that drives m_axis_tvalid.
// The output port, at one byte per cycle, sets the sustained rate; plain
// text, one output byte per item, runs at one item per cycle. When the
// receiver stalls, the output register holds its item, the queue fills and
// s_axis_tready falls once it is full. Reset empties the queue and output
// register and clears any pending escape.
`default_nettype none

module url_percent_decoder
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast
);
    import urlpd_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    bundle_t push_data;
    bundle_t head;

    // Escape tracking and bundle building.
    urlpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_data  (push_data)
    );

    // Bundle queue between the two parts.
    urlpd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    // Byte serializer and output register.
    urlpd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the streaming URL percent decoder.
`default_nettype none

module tb;

    import urlpd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_SET  = 24;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 100;

    // One byte of a stream together with its end-of-string mark.
    typedef struct
    {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;

    // Encoded bytes waiting to be sent and decoded bytes still to arrive.
    stream_byte_t encoded_q[$];
    stream_byte_t decoded_q[$];

    // Decoder state and register copies kept by the testbench.
    phase_t     esc_state = PH_IDLE;
    logic [7:0] held_digit = 8'h00;
    logic       cfg_plus = 1'b0;
    logic       cfg_slash = 1'b1;

    int items_queued = 0;
    int items_accepted = 0;
    int bytes_checked = 0;
    int strings_sent = 0;
    int settings_used = 1;
    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    url_percent_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Value of a hex digit in either case, or -1 for any other byte.
    function automatic int digit_value(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b - "0");
        if (b >= "A" && b <= "F")
            return int'(b - "A") + 10;
        if (b >= "a" && b <= "f")
            return int'(b - "a") + 10;
        return -1;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        decoded_q.push_back('{value: b, last: 1'b0});
    endfunction

    // A byte seen outside an escape: may open one or turn into a space.
    function automatic void take_plain(logic [7:0] b);
        if (cfg_plus && b == CHAR_PLUS)
            emit_byte(CHAR_SPACE);
        else if (b == CHAR_PCT)
            esc_state = PH_PCT;
        else
            emit_byte(b);
    endfunction

    // Work out the decoded bytes that one accepted encoded byte causes.
    function automatic void decode_byte(logic [7:0] b, logic last);
        int         hi;
        int         lo;
        int         start;
        logic [7:0] d;
        start = decoded_q.size();
        case (esc_state)
            PH_PCT:
            begin
                if (digit_value(b) >= 0)
                begin
                    held_digit = b;
                    esc_state = PH_HEX1;
                end
                else
                begin
                    esc_state = PH_IDLE;
                    emit_byte(CHAR_PCT);
                    take_plain(b);
                end
            end
            PH_HEX1:
            begin
                lo = digit_value(b);
                hi = digit_value(held_digit);
                esc_state = PH_IDLE;
                if (lo >= 0)
                begin
                    d = {hi[3:0], lo[3:0]};
                    if (cfg_slash && d == CHAR_SLASH)
                    begin
                        emit_byte(CHAR_PCT);
                        emit_byte(CHAR_TWO);
                        emit_byte(CHAR_UPPER_F);
                    end
                    else
                        emit_byte(d);
                end
                else
                begin
                    emit_byte(CHAR_PCT);
                    emit_byte(held_digit);
                    take_plain(b);
                end
                held_digit = 8'h00;
            end
            default:
            begin
                esc_state = PH_IDLE;
                take_plain(b);
            end
        endcase
        // End of string: flush a truncated escape and mark the final byte.
        if (last)
        begin
            if (esc_state == PH_PCT)
                emit_byte(CHAR_PCT);
            else if (esc_state == PH_HEX1)
            begin
                emit_byte(CHAR_PCT);
                emit_byte(held_digit);
            end
            esc_state = PH_IDLE;
            held_digit = 8'h00;
            if (decoded_q.size() > start)
                decoded_q[decoded_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Driver: offers pending items, idling at random between them.
    always @(posedge clk)
    begin : drive_proc
        stream_byte_t next_item;
        logic         offering;
        offering = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready)
        begin
            decode_byte(s_axis_tdata, s_axis_tlast);
            items_accepted++;
            offering = 1'b0;
        end
        if (!offering)
        begin
            if (rst_n && encoded_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = encoded_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_item.value;
                s_axis_tlast <= next_item.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compares each accepted decoded byte with the oldest expectation.
    always @(posedge clk)
    begin : check_proc
        stream_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_checked++;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual byte %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: out_last mismatch, expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d decoded bytes outstanding",
                     $time, decoded_q.size());
            $display("FAIL url_percent_decoder");
            $finish;
        end
    end

    task automatic add_item(logic [7:0] b, logic last);
        encoded_q.push_back('{value: b, last: last});
        items_queued++;
        if (last)
            strings_sent++;
    endtask

    // Queue the characters of a text, marking the final one if asked.
    task automatic add_text(string txt, logic last_at_end);
        int i;
        for (i = 0; i < txt.len(); i++)
            add_item(txt[i], last_at_end && (i == txt.len() - 1));
    endtask

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return 8'("0") + 8'(v);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (digit_value(b) >= 0);
        return b;
    endfunction

    // Build one random string, mostly well-formed escapes and text.
    task automatic add_random_string();
        logic [7:0] txt[$];
        int         target;
        int         pick;
        int         i;
        target = $urandom_range(12, 1);
        while (txt.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                txt.push_back(8'($urandom_range(8'h7E, 8'h20)));
            else if (pick < 45)
                txt.push_back(CHAR_PLUS);
            else if (pick < 70)
            begin
                txt.push_back(CHAR_PCT);
                if ($urandom_range(3) == 0)
                begin
                    txt.push_back(CHAR_TWO);
                    txt.push_back($urandom_range(1) ? CHAR_UPPER_F : 8'("f"));
                end
                else
                begin
                    txt.push_back(hex_char($urandom_range(15)));
                    txt.push_back(hex_char($urandom_range(15)));
                end
            end
            else if (pick < 80)
            begin
                // Broken escape: bad first or bad second digit.
                txt.push_back(CHAR_PCT);
                if ($urandom_range(1))
                    txt.push_back(hex_char($urandom_range(15)));
                txt.push_back(non_hex_byte());
            end
            else if (pick < 90)
            begin
                // Open escape that the next piece or the end of string resolves.
                txt.push_back(CHAR_PCT);
                if ($urandom_range(1))
                    txt.push_back(hex_char($urandom_range(15)));
            end
            else
                txt.push_back(8'($urandom_range(255)));
        end
        for (i = 0; i < txt.size(); i++)
            add_item(txt[i], i == txt.size() - 1);
    endtask

    task automatic add_random_items(int count);
        int goal;
        goal = items_queued + count;
        while (items_queued < goal)
            add_random_string();
    endtask

    // Wait until every queued item went in and every decoded byte came out.
    task automatic wait_idle();
        while (items_accepted != items_queued || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PLUS_AS_SPACE)
            cfg_plus = val;
        else
            cfg_slash = val;
    endtask

    task automatic apply_setting(logic plus, logic slash, int idle_pct, int stall_pct);
        write_reg(REG_PLUS_AS_SPACE, plus);
        write_reg(REG_KEEP_SLASH, slash);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        settings_used++;
    endtask

    // Stimulus: directed strings first, then random strings per setting.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: valid escapes, an encoded slash kept,
        // a literal plus, broken and doubled escapes, byte extremes, and
        // escapes cut off by the end of the string.
        add_text("%41", 1'b0);
        add_text("%2f", 1'b0);
        add_text("+", 1'b0);
        add_text("%G", 1'b0);
        add_text("%4z", 1'b0);
        add_text("%%41", 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        add_text("%", 1'b1);
        add_text("%a", 1'b1);
        // Leave an escape open across the register change below.
        add_text("%2", 1'b0);
        wait_idle();

        // Slash decoded plainly, plus as space, a plus that breaks an escape.
        apply_setting(1'b1, 1'b0, 0, 0);
        add_text("F", 1'b0);
        add_text("+%4+", 1'b1);
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        apply_setting(1'b0, 1'b0, 79, 0);
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        apply_setting(1'b1, 1'b1, 0, 79);
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        apply_setting(1'b0, 1'b1, 8, 8);
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering.
        apply_setting(1'b1, 1'b0, 0, 0);
        hold_requests++;
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        apply_setting(1'b1, 1'b1, 8, 8);
        add_random_items(ITEMS_PER_SET);
        wait_idle();

        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d decoded bytes never arrived", $time, decoded_q.size());
            errors += decoded_q.size();
        end
        $display("Sent %0d encoded bytes in %0d strings under %0d register settings;",
                 items_accepted, strings_sent, settings_used);
        $display("checked %0d decoded bytes, %0d mismatches.", bytes_checked, errors);
        if (errors == 0)
            $display("PASS url_percent_decoder");
        else
            $display("FAIL url_percent_decoder");
        $finish;
    end

endmodule

`default_nettype wire
